### design/lcpd_pkg.sv
// ----------------------------------------------------------------------------
// lcpd_pkg - shared types and constants for the line-centroid PI omni drive
// Holds field widths, register indexes, reset values, the sequencer state
// type and the operand bundle of the shared multiply-add unit.
// ----------------------------------------------------------------------------
`default_nettype none

package lcpd_pkg;

   // Sensor sample
   localparam int NUM_SENSORS    = 8;
   localparam int SENSOR_W       = 8;
   localparam int ACTIVE_SENSORS = (NUM_SENSORS < SENSOR_W) ? NUM_SENSORS : SENSOR_W;

   // Weighted sum and count of lit sensors
   localparam int SUM_MAX   = ACTIVE_SENSORS * (ACTIVE_SENSORS + 1) / 2;
   localparam int SUM_W     = $clog2(SUM_MAX + 1);
   localparam int CNT_W     = $clog2(ACTIVE_SENSORS + 1);
   localparam int QUOT_W    = SUM_W;
   localparam int DIV_IDX_W = (SUM_W > 1) ? $clog2(SUM_W) : 1;

   // Register field widths
   localparam int TARGET_W  = 4;
   localparam int GAIN_W    = 8;
   localparam int CMD_XY_W  = 9;
   localparam int CMD_ROT_W = 10;
   localparam int MAG_W     = 8;

   // Datapath widths
   localparam int ERR_W    = 6;
   localparam int CORR_W   = 16;
   localparam int WHEEL_W  = 18;
   localparam int ALU_A_W  = 18;
   localparam int ALU_B_W  = 9;
   localparam int ALU_C_W  = 18;
   localparam int ALU_Y_W  = ALU_A_W + ALU_B_W + 1;
   localparam int CORR_MAX = 2 ** (CORR_W - 1) - 1;
   localparam int CORR_MIN = -(2 ** (CORR_W - 1));

   localparam logic signed [ALU_B_W-1:0] B_ONE     = ALU_B_W'(1);
   localparam logic signed [ALU_B_W-1:0] B_NEG_ONE = ALU_B_W'(-1);

   // Configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 10;

   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_POSITION = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_PROP_GAIN       = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_INTEG_GAIN      = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] CSR_CMD_X           = CSR_IDX_W'(3);
   localparam logic [CSR_IDX_W-1:0] CSR_CMD_Y           = CSR_IDX_W'(4);
   localparam logic [CSR_IDX_W-1:0] CSR_CMD_ROT         = CSR_IDX_W'(5);
   localparam logic [CSR_IDX_W-1:0] CSR_DEAD_BAND       = CSR_IDX_W'(6);
   localparam logic [CSR_IDX_W-1:0] CSR_DRIVE_LIMIT     = CSR_IDX_W'(7);

   typedef struct packed {
      logic [TARGET_W-1:0]  target_position;
      logic [GAIN_W-1:0]    prop_gain;
      logic [GAIN_W-1:0]    integ_gain;
      logic [CMD_XY_W-1:0]  cmd_x;
      logic [CMD_XY_W-1:0]  cmd_y;
      logic [CMD_ROT_W-1:0] cmd_rot;
      logic [MAG_W-1:0]     dead_band;
      logic [MAG_W-1:0]     drive_limit;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      target_position: TARGET_W'(4),
      prop_gain:       GAIN_W'(8),
      integ_gain:      GAIN_W'(0),
      cmd_x:           CMD_XY_W'(0),
      cmd_y:           CMD_XY_W'(100),
      cmd_rot:         CMD_ROT_W'(0),
      dead_band:       MAG_W'(15),
      drive_limit:     MAG_W'(255)
   };

   // Wheel direction codes
   typedef enum logic [1:0] {
      DIR_STOP = 2'd0,
      DIR_FWD  = 2'd1,
      DIR_REV  = 2'd2
   } dir_type;

   typedef struct packed {
      dir_type          dir;
      logic [MAG_W-1:0] duty;
   } wheel_type;

   // Operands of the shared multiply-add unit: y = a * b + c
   typedef struct packed {
      logic [ALU_A_W-1:0] a;
      logic [ALU_B_W-1:0] b;
      logic [ALU_C_W-1:0] c;
   } alu_req_type;

   // Sequencer states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIV,
      ST_ERR,
      ST_INTEG,
      ST_PROP,
      ST_BASE,
      ST_W1,
      ST_W2A,
      ST_W2B,
      ST_W3A,
      ST_W3B,
      ST_LOAD
   } state_type;

endpackage

`default_nettype wire

### design/lcpd_req_if.sv
// ----------------------------------------------------------------------------
// lcpd_req_if - sensor sample request channel
// Valid/ready channel carrying one line-sensor sample per request.
// ----------------------------------------------------------------------------
`default_nettype none

interface lcpd_req_if import lcpd_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [SENSOR_W-1:0] sensor_bits;

   modport source (output valid, output sensor_bits, input ready);
   modport sink   (input valid, input sensor_bits, output ready);
endinterface

`default_nettype wire

### design/lcpd_rsp_if.sv
// ----------------------------------------------------------------------------
// lcpd_rsp_if - wheel drive response channel
// Valid/ready channel carrying three wheel commands, the line-lost flag and
// the correction used for the sample.
// ----------------------------------------------------------------------------
`default_nettype none

interface lcpd_rsp_if import lcpd_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [1:0]               wheel_one_dir;
   logic [MAG_W-1:0]         wheel_one_duty;
   logic [1:0]               wheel_two_dir;
   logic [MAG_W-1:0]         wheel_two_duty;
   logic [1:0]               wheel_three_dir;
   logic [MAG_W-1:0]         wheel_three_duty;
   logic                     line_lost;
   logic signed [CORR_W-1:0] correction;

   modport source (
      output valid, input ready,
      output wheel_one_dir, output wheel_one_duty,
      output wheel_two_dir, output wheel_two_duty,
      output wheel_three_dir, output wheel_three_duty,
      output line_lost, output correction
   );
   modport sink (
      input valid, output ready,
      input wheel_one_dir, input wheel_one_duty,
      input wheel_two_dir, input wheel_two_duty,
      input wheel_three_dir, input wheel_three_duty,
      input line_lost, input correction
   );
endinterface

`default_nettype wire

### design/lcpd_csr.sv
// ----------------------------------------------------------------------------
// lcpd_csr - configuration register file
// Write-only register bank for target, gains, drive commands, deadband and
// wheel limit; each write stores the low bits of the data at one index.
// ----------------------------------------------------------------------------
`default_nettype none

module lcpd_csr import lcpd_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  wr_en,
   input  logic [CSR_IDX_W-1:0]  index,
   input  logic [CSR_DATA_W-1:0] wr_data,
   output cfg_type               cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Decode the write
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (index)
            CSR_TARGET_POSITION: cfg_in.target_position = wr_data[TARGET_W-1:0];
            CSR_PROP_GAIN:       cfg_in.prop_gain       = wr_data[GAIN_W-1:0];
            CSR_INTEG_GAIN:      cfg_in.integ_gain      = wr_data[GAIN_W-1:0];
            CSR_CMD_X:           cfg_in.cmd_x           = wr_data[CMD_XY_W-1:0];
            CSR_CMD_Y:           cfg_in.cmd_y           = wr_data[CMD_XY_W-1:0];
            CSR_CMD_ROT:         cfg_in.cmd_rot         = wr_data[CMD_ROT_W-1:0];
            CSR_DEAD_BAND:       cfg_in.dead_band       = wr_data[MAG_W-1:0];
            CSR_DRIVE_LIMIT:     cfg_in.drive_limit     = wr_data[MAG_W-1:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   // Hold the registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

### design/lcpd_alu.sv
// ----------------------------------------------------------------------------
// lcpd_alu - shared signed multiply-add unit
// Computes a * b + c on signed operands; the sequencer uses it for division
// steps, the PI terms and the wheel mixing.
// ----------------------------------------------------------------------------
`default_nettype none

module lcpd_alu import lcpd_pkg::*; (
   input  alu_req_type               req,
   output logic signed [ALU_Y_W-1:0] y
);

   logic signed [ALU_A_W-1:0]         op_a;
   logic signed [ALU_B_W-1:0]         op_b;
   logic signed [ALU_C_W-1:0]         op_c;
   logic signed [ALU_A_W+ALU_B_W-1:0] prod;

   assign op_a = req.a;
   assign op_b = req.b;
   assign op_c = req.c;

   // Multiply, then add the offset at full width
   assign prod = op_a * op_b;
   assign y    = ALU_Y_W'(prod) + ALU_Y_W'(op_c);

endmodule

`default_nettype wire

### design/line_centroid_pid_omni_drive.sv
// ----------------------------------------------------------------------------
// line_centroid_pid_omni_drive - line-following PI controller, omni base
// Sequence: a request with a sensor lit runs the restoring-division steps,
//   9 multiply-add steps and a load into the response register; with no
//   sensor lit it skips the division, error and PI steps. A new request is
//   taken only in the idle state, once the last response is loaded; every
//   step uses the single shared multiply-add unit, one operation per cycle.
//   Reset: synchronous, active high; clears the sequencer, the response valid,
//   the integrator and the held correction, and loads the register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module line_centroid_pid_omni_drive import lcpd_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   lcpd_req_if.sink              req_chan,
   lcpd_rsp_if.source            rsp_chan,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wr_data
);

   localparam logic signed [ALU_Y_W-1:0] Y_CORR_MAX = ALU_Y_W'(CORR_MAX);
   localparam logic signed [ALU_Y_W-1:0] Y_CORR_MIN = ALU_Y_W'(CORR_MIN);

   // Saturate a multiply-add result to the correction width
   function automatic logic signed [CORR_W-1:0] sat_corr(
      input logic signed [ALU_Y_W-1:0] v
   );
      logic signed [CORR_W-1:0] r;
      if (v > Y_CORR_MAX) begin
         r = CORR_W'(CORR_MAX);
      end else if (v < Y_CORR_MIN) begin
         r = CORR_W'(CORR_MIN);
      end else begin
         r = v[CORR_W-1:0];
      end
      return r;
   endfunction

   // Clamp a wheel value to the limit, apply the deadband, split dir/duty
   function automatic wheel_type drive(
      input logic signed [ALU_Y_W-1:0] v,
      input logic [MAG_W-1:0]          lim,
      input logic [MAG_W-1:0]          db
   );
      logic signed [ALU_Y_W-1:0] lim_s;
      logic signed [ALU_Y_W-1:0] db_s;
      logic signed [ALU_Y_W-1:0] clv;
      logic signed [ALU_Y_W-1:0] neg;
      wheel_type                 w;
      lim_s = ALU_Y_W'(lim);
      db_s  = ALU_Y_W'(db);
      if (v > lim_s) begin
         clv = lim_s;
      end else if (v < -lim_s) begin
         clv = -lim_s;
      end else begin
         clv = v;
      end
      neg = -clv;
      if (clv < -db_s) begin
         w.dir  = DIR_REV;
         w.duty = neg[MAG_W-1:0];
      end else if (clv > db_s) begin
         w.dir  = DIR_FWD;
         w.duty = clv[MAG_W-1:0];
      end else begin
         w.dir  = DIR_STOP;
         w.duty = '0;
      end
      return w;
   endfunction

   cfg_type                    cfg;
   alu_req_type                alu_req;
   logic signed [ALU_Y_W-1:0]  alu_y;

   logic signed [CMD_XY_W-1:0]  cmd_x_s;
   logic signed [CMD_XY_W-1:0]  cmd_y_s;
   logic signed [CMD_ROT_W-1:0] cmd_rot_s;
   logic signed [CMD_ROT_W:0]   rot_adj;
   logic signed [CMD_ROT_W-1:0] half_rot;

   logic [SUM_W-1:0]  sum_calc;
   logic [CNT_W-1:0]  cnt_calc;
   logic [CNT_W:0]    div_shift;
   logic              div_bit;

   state_type                 state_ff, state_in;
   logic [DIV_IDX_W-1:0]      div_idx_ff, div_idx_in;
   logic [SUM_W-1:0]          sum_ff, sum_in;
   logic [CNT_W-1:0]          cnt_ff, cnt_in;
   logic [CNT_W-1:0]          rem_ff, rem_in;
   logic [QUOT_W-1:0]         quot_ff, quot_in;
   logic signed [ERR_W-1:0]   err_ff, err_in;
   logic signed [CORR_W-1:0]  integ_ff, integ_in;
   logic signed [CORR_W-1:0]  held_ff, held_in;
   logic signed [CORR_W-1:0]  corr_ff, corr_in;
   logic                      lost_ff, lost_in;
   logic signed [WHEEL_W-1:0] base_ff, base_in;
   logic signed [WHEEL_W-1:0] tmp_ff, tmp_in;
   wheel_type                 w1_ff, w1_in;
   wheel_type                 w2_ff, w2_in;
   wheel_type                 w3_ff, w3_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   wheel_type                 out1_ff, out1_in;
   wheel_type                 out2_ff, out2_in;
   wheel_type                 out3_ff, out3_in;
   logic                      out_lost_ff, out_lost_in;
   logic signed [CORR_W-1:0]  out_corr_ff, out_corr_in;

   lcpd_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (csr_wr_en),
      .index   (csr_index),
      .wr_data (csr_wr_data),
      .cfg     (cfg)
   );

   lcpd_alu u_alu (
      .req (alu_req),
      .y   (alu_y)
   );

   // Signed views of the drive commands; halve rotation toward zero
   assign cmd_x_s   = cfg.cmd_x;
   assign cmd_y_s   = cfg.cmd_y;
   assign cmd_rot_s = cfg.cmd_rot;
   assign rot_adj   = {cmd_rot_s[CMD_ROT_W-1], cmd_rot_s}
                    + {{CMD_ROT_W{1'b0}}, cmd_rot_s[CMD_ROT_W-1]};
   assign half_rot  = rot_adj[CMD_ROT_W:1];

   // Weight and count the lit sensors of the incoming request
   always_comb begin
      sum_calc = '0;
      cnt_calc = '0;
      for (int i = 0; i < ACTIVE_SENSORS; i++) begin
         if (req_chan.sensor_bits[i]) begin
            sum_calc = sum_calc + SUM_W'(i + 1);
            cnt_calc = cnt_calc + CNT_W'(1);
         end
      end
   end

   // Restoring division step: bring down the next dividend bit
   assign div_shift = {rem_ff, sum_ff[SUM_W-1]};
   assign div_bit   = ~alu_y[ALU_Y_W-1];

   assign req_chan.ready = (state_ff == ST_IDLE);

   // Sequencer: operand select, next state and working registers
   always_comb begin
      state_in     = state_ff;
      div_idx_in   = div_idx_ff;
      sum_in       = sum_ff;
      cnt_in       = cnt_ff;
      rem_in       = rem_ff;
      quot_in      = quot_ff;
      err_in       = err_ff;
      integ_in     = integ_ff;
      held_in      = held_ff;
      corr_in      = corr_ff;
      lost_in      = lost_ff;
      base_in      = base_ff;
      tmp_in       = tmp_ff;
      w1_in        = w1_ff;
      w2_in        = w2_ff;
      w3_in        = w3_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      out1_in      = out1_ff;
      out2_in      = out2_ff;
      out3_in      = out3_ff;
      out_lost_in  = out_lost_ff;
      out_corr_in  = out_corr_ff;
      alu_req.a    = '0;
      alu_req.b    = B_ONE;
      alu_req.c    = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               sum_in     = sum_calc;
               cnt_in     = cnt_calc;
               rem_in     = '0;
               quot_in    = '0;
               div_idx_in = DIV_IDX_W'(SUM_W - 1);
               if (cnt_calc == '0) begin
                  lost_in  = 1'b1;
                  corr_in  = held_ff;
                  state_in = ST_BASE;
               end else begin
                  lost_in  = 1'b0;
                  state_in = ST_DIV;
               end
            end
         end
         ST_DIV: begin
            alu_req.a = ALU_A_W'(div_shift);
            alu_req.b = B_ONE;
            alu_req.c = ALU_C_W'(0) - ALU_C_W'(cnt_ff);
            rem_in    = div_bit ? alu_y[CNT_W-1:0] : div_shift[CNT_W-1:0];
            quot_in   = {quot_ff[QUOT_W-2:0], div_bit};
            sum_in    = {sum_ff[SUM_W-2:0], 1'b0};
            if (div_idx_ff == '0) begin
               state_in = ST_ERR;
            end else begin
               div_idx_in = div_idx_ff - DIV_IDX_W'(1);
            end
         end
         ST_ERR: begin
            alu_req.a = ALU_A_W'(quot_ff);
            alu_req.b = B_ONE;
            alu_req.c = ALU_C_W'(0) - ALU_C_W'(cfg.target_position);
            err_in    = alu_y[ERR_W-1:0];
            state_in  = ST_INTEG;
         end
         ST_INTEG: begin
            alu_req.a = ALU_A_W'(err_ff);
            alu_req.b = ALU_B_W'({1'b0, cfg.integ_gain});
            alu_req.c = ALU_C_W'(integ_ff);
            integ_in  = sat_corr(alu_y);
            state_in  = ST_PROP;
         end
         ST_PROP: begin
            alu_req.a = ALU_A_W'(err_ff);
            alu_req.b = ALU_B_W'({1'b0, cfg.prop_gain});
            alu_req.c = ALU_C_W'(integ_ff);
            corr_in   = sat_corr(alu_y);
            held_in   = sat_corr(alu_y);
            state_in  = ST_BASE;
         end
         ST_BASE: begin
            alu_req.a = ALU_A_W'(corr_ff);
            alu_req.b = B_ONE;
            alu_req.c = ALU_C_W'(cmd_x_s);
            base_in   = alu_y[WHEEL_W-1:0];
            state_in  = ST_W1;
         end
         ST_W1: begin
            alu_req.a = ALU_A_W'(half_rot);
            alu_req.b = B_ONE;
            alu_req.c = ALU_C_W'(base_ff);
            w1_in     = drive(alu_y, cfg.drive_limit, cfg.dead_band);
            state_in  = ST_W2A;
         end
         ST_W2A: begin
            alu_req.a = ALU_A_W'(cmd_y_s);
            alu_req.b = B_NEG_ONE;
            alu_req.c = ALU_C_W'(base_ff);
            tmp_in    = alu_y[WHEEL_W-1:0];
            state_in  = ST_W2B;
         end
         ST_W2B: begin
            alu_req.a = ALU_A_W'(half_rot);
            alu_req.b = B_ONE;
            alu_req.c = ALU_C_W'(tmp_ff);
            w2_in     = drive(alu_y, cfg.drive_limit, cfg.dead_band);
            state_in  = ST_W3A;
         end
         ST_W3A: begin
            alu_req.a = ALU_A_W'(cmd_y_s);
            alu_req.b = B_ONE;
            alu_req.c = ALU_C_W'(base_ff);
            tmp_in    = alu_y[WHEEL_W-1:0];
            state_in  = ST_W3B;
         end
         ST_W3B: begin
            alu_req.a = ALU_A_W'(half_rot);
            alu_req.b = B_NEG_ONE;
            alu_req.c = ALU_C_W'(tmp_ff);
            w3_in     = drive(alu_y, cfg.drive_limit, cfg.dead_band);
            state_in  = ST_LOAD;
         end
         ST_LOAD: begin
            // Load the response register once it is free
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               out1_in      = w1_ff;
               out2_in      = w2_ff;
               out3_in      = w3_ff;
               out_lost_in  = lost_ff;
               out_corr_in  = corr_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state and controller memory
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         integ_ff     <= '0;
         held_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         integ_ff     <= integ_in;
         held_ff      <= held_in;
      end
   end

   // Working and response payload
   always_ff @(posedge clock) begin
      div_idx_ff  <= div_idx_in;
      sum_ff      <= sum_in;
      cnt_ff      <= cnt_in;
      rem_ff      <= rem_in;
      quot_ff     <= quot_in;
      err_ff      <= err_in;
      corr_ff     <= corr_in;
      lost_ff     <= lost_in;
      base_ff     <= base_in;
      tmp_ff      <= tmp_in;
      w1_ff       <= w1_in;
      w2_ff       <= w2_in;
      w3_ff       <= w3_in;
      out1_ff     <= out1_in;
      out2_ff     <= out2_in;
      out3_ff     <= out3_in;
      out_lost_ff <= out_lost_in;
      out_corr_ff <= out_corr_in;
   end

   // Drive the response channel
   assign rsp_chan.valid            = rsp_valid_ff;
   assign rsp_chan.wheel_one_dir    = out1_ff.dir;
   assign rsp_chan.wheel_one_duty   = out1_ff.duty;
   assign rsp_chan.wheel_two_dir    = out2_ff.dir;
   assign rsp_chan.wheel_two_duty   = out2_ff.duty;
   assign rsp_chan.wheel_three_dir  = out3_ff.dir;
   assign rsp_chan.wheel_three_duty = out3_ff.duty;
   assign rsp_chan.line_lost        = out_lost_ff;
   assign rsp_chan.correction       = out_corr_ff;

   // A request with no lit sensor reuses the held correction
   a_lost_holds_corr: assert property (@(posedge clock) disable iff (reset)
      req_chan.valid && req_chan.ready && (req_chan.sensor_bits == '0)
      |=> lost_ff && (corr_ff == $past(held_ff)) && (state_ff == ST_BASE))
      else $error("lost line did not take the held correction");

   // A request with no lit sensor leaves the controller memory alone
   a_lost_keeps_state: assert property (@(posedge clock) disable iff (reset)
      req_chan.valid && req_chan.ready && (req_chan.sensor_bits == '0)
      |=> $stable(integ_ff) && $stable(held_ff))
      else $error("integrator or held correction changed on lost line");

   // The centroid is always a valid sensor weight
   a_quot_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ERR)
      |-> (quot_ff >= QUOT_W'(1)) && (quot_ff <= QUOT_W'(ACTIVE_SENSORS)))
      else $error("centroid out of range");

   // A stopped wheel has zero duty and a moving wheel a nonzero one
   a_dir_duty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff
      |-> ((out1_ff.dir == DIR_STOP) == (out1_ff.duty == '0))
       && ((out2_ff.dir == DIR_STOP) == (out2_ff.duty == '0))
       && ((out3_ff.dir == DIR_STOP) == (out3_ff.duty == '0)))
      else $error("wheel direction and duty disagree");

endmodule

`default_nettype wire

### bench/lcpd_drive_checker.sv
// ----------------------------------------------------------------------------
// lcpd_drive_checker - wheel command predictor and response comparator
// Watches the sensor request channel, the wheel response channel and the
// register write port. Keeps a private copy of the controller registers and
// of the PI state. Computes the wheel commands due for every accepted
// request and compares each accepted response, field by field, with the
// oldest command still due.
// ----------------------------------------------------------------------------

module lcpd_drive_checker import lcpd_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   lcpd_req_if                   req_mon,
   lcpd_rsp_if                   rsp_mon,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wr_data,
   output int                    mismatch_count,
   output int                    pending_count
);

   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      wheel_type                one;
      wheel_type                two;
      wheel_type                three;
      logic                     line_lost;
      logic signed [CORR_W-1:0] correction;
   } drive_cmd_type;

   cfg_type       controls;
   int            integ_acc;
   int            held_corr;
   int            bad_count;
   drive_cmd_type cmds_due[$];
   drive_cmd_type want;

   function automatic int sat16(input int v);
      if (v > CORR_MAX) return CORR_MAX;
      if (v < CORR_MIN) return CORR_MIN;
      return v;
   endfunction

   // Clamp to the drive limit, then stop inside the deadband
   function automatic wheel_type wheel_drive(input int level);
      int        lim;
      int        db;
      wheel_type w;
      lim = int'(controls.drive_limit);
      db  = int'(controls.dead_band);
      if (level > lim) level = lim;
      else if (level < -lim) level = -lim;
      if (level < -db) begin
         w.dir  = DIR_REV;
         w.duty = MAG_W'(-level);
      end else if (level > db) begin
         w.dir  = DIR_FWD;
         w.duty = MAG_W'(level);
      end else begin
         w.dir  = DIR_STOP;
         w.duty = '0;
      end
      return w;
   endfunction

   // Centroid, PI update and three-wheel mix for one sensor request
   function automatic drive_cmd_type predict_drive(input logic [SENSOR_W-1:0] pattern);
      int            weight_sum;
      int            lit;
      int            err;
      int            corr;
      int            side;
      int            fwd;
      int            half;
      int            i;
      drive_cmd_type cmd;
      weight_sum = 0;
      lit        = 0;
      for (i = 0; i < ACTIVE_SENSORS; i++) begin
         if (pattern[i]) begin
            weight_sum += i + 1;
            lit++;
         end
      end
      if (lit == 0) begin
         // Line lost: hold the integrator and reuse the last correction
         cmd.line_lost = 1'b1;
         corr = held_corr;
      end else begin
         err       = weight_sum / lit - int'(controls.target_position);
         integ_acc = sat16(integ_acc + err * int'(controls.integ_gain));
         corr      = sat16(err * int'(controls.prop_gain) + integ_acc);
         held_corr = corr;
         cmd.line_lost = 1'b0;
      end
      side = int'($signed(controls.cmd_x));
      fwd  = int'($signed(controls.cmd_y));
      half = int'($signed(controls.cmd_rot)) / 2;
      cmd.one        = wheel_drive(half + side + corr);
      cmd.two        = wheel_drive(half - fwd + side + corr);
      cmd.three      = wheel_drive(-half + fwd + side + corr);
      cmd.correction = CORR_W'(corr);
      return cmd;
   endfunction

   task automatic check_field(input string field, input int exp_val, input int act_val);
      if (exp_val != act_val) begin
         if (bad_count < REPORT_LIMIT)
            $display("%0t: %s differs: expected %0d, actual %0d",
                     $time, field, exp_val, act_val);
         bad_count++;
      end
   endtask

   // Compare responses first, then queue the prediction for a new request
   always @(posedge clock) begin
      if (reset) begin
         controls  = CFG_RESET;
         integ_acc = 0;
         held_corr = 0;
         bad_count = 0;
         cmds_due.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (cmds_due.size() == 0) begin
               if (bad_count < REPORT_LIMIT)
                  $display("%0t: response with no request outstanding", $time);
               bad_count++;
            end else begin
               want = cmds_due.pop_front();
               check_field("wheel_one_dir", want.one.dir, rsp_mon.wheel_one_dir);
               check_field("wheel_one_duty", want.one.duty, rsp_mon.wheel_one_duty);
               check_field("wheel_two_dir", want.two.dir, rsp_mon.wheel_two_dir);
               check_field("wheel_two_duty", want.two.duty, rsp_mon.wheel_two_duty);
               check_field("wheel_three_dir", want.three.dir, rsp_mon.wheel_three_dir);
               check_field("wheel_three_duty", want.three.duty, rsp_mon.wheel_three_duty);
               check_field("line_lost", want.line_lost, rsp_mon.line_lost);
               check_field("correction", want.correction, rsp_mon.correction);
            end
         end
         if (req_mon.valid && req_mon.ready)
            cmds_due.push_back(predict_drive(req_mon.sensor_bits));
         // Mirror register writes, masked to each register's width
         if (csr_wr_en) begin
            case (csr_index)
               CSR_TARGET_POSITION: controls.target_position = csr_wr_data[TARGET_W-1:0];
               CSR_PROP_GAIN:       controls.prop_gain       = csr_wr_data[GAIN_W-1:0];
               CSR_INTEG_GAIN:      controls.integ_gain      = csr_wr_data[GAIN_W-1:0];
               CSR_CMD_X:           controls.cmd_x           = csr_wr_data[CMD_XY_W-1:0];
               CSR_CMD_Y:           controls.cmd_y           = csr_wr_data[CMD_XY_W-1:0];
               CSR_CMD_ROT:         controls.cmd_rot         = csr_wr_data[CMD_ROT_W-1:0];
               CSR_DEAD_BAND:       controls.dead_band       = csr_wr_data[MAG_W-1:0];
               CSR_DRIVE_LIMIT:     controls.drive_limit     = csr_wr_data[MAG_W-1:0];
               default: ;
            endcase
         end
      end
      mismatch_count <= bad_count;
      pending_count  <= cmds_due.size();
   end

endmodule

### bench/tb_line_centroid_pid_omni_drive.sv
// ----------------------------------------------------------------------------
// tb_line_centroid_pid_omni_drive - line follower PI omni drive testbench
// Sends line-sensor requests under a sequence of register settings, from the
// reset defaults through the gain, command and clamp extremes to random
// settings, with random gaps on both channels. A checker beside the block
// predicts every response; this module drives stimulus and gives the verdict.
// ----------------------------------------------------------------------------

module tb_line_centroid_pid_omni_drive import lcpd_pkg::*; ();

   localparam int STALL_LIMIT   = 2000;
   localparam int SETTLE_CYCLES = 20;
   localparam int END_CYCLES    = 40;
   localparam int PHASE_ITEMS   = 150;
   localparam int RANDOM_PHASES = 9;
   localparam int QUIET_PHASE   = 5;

   logic                  clock;
   logic                  reset;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wr_data;
   bit                    throttle;
   int                    mismatches;
   int                    pending;
   int                    sent_count;
   int                    settings_used;
   int                    stall_cycles;

   lcpd_req_if req_chan ();
   lcpd_rsp_if rsp_chan ();

   line_centroid_pid_omni_drive DUT (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   lcpd_drive_checker drive_check (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_chan),
      .rsp_mon        (rsp_chan),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wr_data    (csr_wr_data),
      .mismatch_count (mismatches),
      .pending_count  (pending)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Stall the response channel at random
   initial begin
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_chan.ready = !(throttle && $urandom_range(0, 99) < 13);
      end
   end

   // End the run when neither channel moves for too long
   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         stall_cycles = 0;
      else
         stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("timeout: no request or response moved in %0d cycles", STALL_LIMIT);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // Offer one request; return at the falling edge after it is taken
   task automatic send_sample(input logic [SENSOR_W-1:0] pattern);
      while (throttle && $urandom_range(0, 99) < 13) begin
         req_chan.valid = 1'b0;
         @(negedge clock);
      end
      req_chan.valid       = 1'b1;
      req_chan.sensor_bits = pattern;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      @(negedge clock);
      sent_count++;
   endtask

   // Hold requests until every response is back, then let the block settle
   task automatic drain_responses();
      req_chan.valid = 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input int value);
      csr_wr_en   = 1'b1;
      csr_index   = idx;
      csr_wr_data = CSR_DATA_W'(value);
      @(negedge clock);
      csr_wr_en   = 1'b0;
   endtask

   task automatic set_controls(input int tgt, input int kp, input int ki, input int side,
                               input int fwd, input int rot, input int db, input int lim);
      write_reg(CSR_TARGET_POSITION, tgt);
      write_reg(CSR_PROP_GAIN, kp);
      write_reg(CSR_INTEG_GAIN, ki);
      write_reg(CSR_CMD_X, side);
      write_reg(CSR_CMD_Y, fwd);
      write_reg(CSR_CMD_ROT, rot);
      write_reg(CSR_DEAD_BAND, db);
      write_reg(CSR_DRIVE_LIMIT, lim);
      settings_used++;
   endtask

   // Mostly a narrow line under the array, some lost line, some noise
   function automatic logic [SENSOR_W-1:0] line_pattern();
      int run;
      int pos;
      case ($urandom_range(0, 9))
         0: return '0;
         1, 2: return SENSOR_W'($urandom_range(0, 255));
         default: begin
            run = $urandom_range(1, 3);
            pos = $urandom_range(0, SENSOR_W - run);
            return SENSOR_W'(((1 << run) - 1) << pos);
         end
      endcase
   endfunction

   task automatic apply_setting(input int phase);
      case (phase)
         0: set_controls(4, 8, 0, 0, 100, 0, 15, 255);
         1: set_controls(1, 255, 255, 255, -255, 510, 0, 255);
         2: set_controls(8, 255, 255, -255, 255, -510, 255, 0);
         3: set_controls(0, 0, 0, 0, 0, 0, 0, 0);
         4: set_controls(15, 1, 3, -1, 1, -1, 1, 128);
         default: set_controls($urandom_range(0, 1023), $urandom_range(0, 1023),
                               $urandom_range(0, 1023), $urandom_range(0, 1023),
                               $urandom_range(0, 1023), $urandom_range(0, 1023),
                               $urandom_range(0, 47), $urandom_range(0, 1023));
      endcase
   endtask

   initial begin
      reset                = 1'b1;
      req_chan.valid       = 1'b0;
      req_chan.sensor_bits = '0;
      csr_wr_en            = 1'b0;
      csr_index            = '0;
      csr_wr_data          = '0;
      throttle             = 1'b1;
      sent_count           = 0;
      settings_used        = 1;
      stall_cycles         = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Reset defaults: lost line before any correction, extremes, held value
      send_sample(8'h00);
      send_sample(8'hFF);
      send_sample(8'h01);
      send_sample(8'h80);
      send_sample(8'h00);
      send_sample(8'h18);
      send_sample(8'h0F);
      send_sample(8'hF0);
      send_sample(8'h55);
      send_sample(8'hAA);
      drain_responses();

      // Top gains and commands, no deadband: integrator climbs fast
      set_controls(1, 255, 255, 255, -255, 510, 0, 255);
      send_sample(8'h80);
      send_sample(8'h80);
      send_sample(8'h80);
      send_sample(8'h01);
      send_sample(8'h00);
      send_sample(8'hFF);
      drain_responses();

      // Limit at or under the deadband: every wheel stops
      set_controls(8, 255, 255, -255, 255, -510, 255, 0);
      send_sample(8'h01);
      send_sample(8'hFF);
      send_sample(8'h00);
      send_sample(8'h80);
      drain_responses();

      // Random requests, one register setting per phase
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         apply_setting(phase);
         throttle = (phase != QUIET_PHASE);
         repeat (PHASE_ITEMS) send_sample(line_pattern());
         drain_responses();
      end
      throttle = 1'b1;

      drain_responses();
      repeat (END_CYCLES) @(posedge clock);
      $display("Summary: %0d sensor requests under %0d register settings,",
               sent_count, settings_used);
      $display("  gains, commands and clamps at their extremes, channels stalled at random");
      if (mismatches == 0 && pending == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("%0d field mismatches, %0d responses outstanding", mismatches, pending);
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

### sim.f
design/lcpd_pkg.sv
design/lcpd_req_if.sv
design/lcpd_rsp_if.sv
design/lcpd_csr.sv
design/lcpd_alu.sv
design/line_centroid_pid_omni_drive.sv
bench/lcpd_drive_checker.sv
bench/tb_line_centroid_pid_omni_drive.sv
